// ----- design/lrm_pkg.sv -----
`timescale 1ns / 1ps

package lrm_pkg;

  // Sine quarter-wave table depth used when the top level is not overridden.
  localparam int SINE_DEPTH_DEF = 256;

  // Configuration port geometry: two 32-bit registers at byte offsets 0 and 4.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_MIN_RATE = 1'b0;
  localparam logic REG_MAX_RATE = 1'b1;

  // Register reset values, unsigned Q8.16.
  localparam logic [23:0] MIN_RATE_RST = 24'd655;
  localparam logic [23:0] MAX_RATE_RST = 24'd1310720;

  // Waveform shape codes.
  localparam logic [1:0] SHAPE_SINE     = 2'd0;
  localparam logic [1:0] SHAPE_TRIANGLE = 2'd1;
  localparam logic [1:0] SHAPE_SQUARE   = 2'd2;
  localparam logic [1:0] SHAPE_SAW      = 2'd3;

  // Full scale in Q2.15.
  localparam logic signed [16:0] ONE_Q15     = 17'sd32768;
  localparam logic signed [16:0] NEG_ONE_Q15 = -17'sd32768;

  // Constants of the sine series used to build the quarter-wave table.
  localparam longint unsigned PI_Q30 = 64'd3373259426;
  localparam longint unsigned SERIES_DIV [8] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
  };

  // Rate limits from the register file.
  typedef struct packed {
    logic [23:0] min_rate;
    logic [23:0] max_rate;
  } cfg_t;

  // Route fields that ride along the pipeline.
  typedef struct packed {
    logic               wr_en;
    logic               last;
    logic               uni;
    logic [1:0]         shape;
    logic signed [16:0] depth;
    logic signed [31:0] base;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    logic signed [32:0] diff;
  } side_t;

  // Beat leaving the phase unit.
  typedef struct packed {
    logic        valid;
    side_t       side;
    logic [15:0] phase;
  } phs_beat_t;

  // Beat leaving the waveform unit.
  typedef struct packed {
    logic               valid;
    side_t              side;
    logic signed [16:0] wave;
  } wav_beat_t;

endpackage

// ----- design/lrm_in_if.sv -----
`timescale 1ns / 1ps

interface lrm_in_if;
  logic               valid;
  logic               ready;
  logic [31:0]        time_seconds;
  logic [1:0]         lfo_shape;
  logic [23:0]        lfo_rate;
  logic [15:0]        start_phase;
  logic               unipolar;
  logic               source_active;
  logic signed [16:0] route_depth;
  logic signed [31:0] base_value;
  logic signed [31:0] range_minimum;
  logic signed [31:0] range_maximum;
  logic               target_present;
  logic               last_entry;

  modport source (
    output valid, time_seconds, lfo_shape, lfo_rate, start_phase, unipolar,
           source_active, route_depth, base_value, range_minimum, range_maximum,
           target_present, last_entry,
    input  ready
  );

  modport sink (
    input  valid, time_seconds, lfo_shape, lfo_rate, start_phase, unipolar,
           source_active, route_depth, base_value, range_minimum, range_maximum,
           target_present, last_entry,
    output ready
  );
endinterface

// ----- design/lrm_out_if.sv -----
`timescale 1ns / 1ps

interface lrm_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] written_value;
  logic               write_enable;
  logic               last_result;

  modport source (
    output valid, written_value, write_enable, last_result,
    input  ready
  );

  modport sink (
    input  valid, written_value, write_enable, last_result,
    output ready
  );
endinterface

// ----- design/lrm_cfg_regs.sv -----
`timescale 1ns / 1ps

module lrm_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lrm_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [lrm_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [lrm_pkg::CFG_DATA_W-1:0] prdata,
  output logic                          pready,
  output lrm_pkg::cfg_t                 cfg
);
  import lrm_pkg::*;

  logic [23:0] min_rate_r;
  logic [23:0] max_rate_r;
  logic        reg_sel;
  logic        wr_stb;

  // The word offset selects the register; the access phase commits a write.
  assign reg_sel = paddr[CFG_ADDR_W-1];
  assign wr_stb  = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_rate_r <= MIN_RATE_RST;
      max_rate_r <= MAX_RATE_RST;
    end else if (wr_stb) begin
      case (reg_sel)
        REG_MIN_RATE: min_rate_r <= pwdata[23:0];
        REG_MAX_RATE: max_rate_r <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  // Read data is the selected register, zero extended.
  always_comb begin
    case (reg_sel)
      REG_MIN_RATE: prdata = CFG_DATA_W'(min_rate_r);
      REG_MAX_RATE: prdata = CFG_DATA_W'(max_rate_r);
      default:      prdata = '0;
    endcase
  end

  assign cfg.min_rate = min_rate_r;
  assign cfg.max_rate = max_rate_r;

endmodule

// ----- design/lrm_phase.sv -----
`timescale 1ns / 1ps

module lrm_phase (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  lrm_pkg::cfg_t      cfg,
  lrm_in_if.sink             in_ch,
  output lrm_pkg::phs_beat_t ph_beat
);
  import lrm_pkg::*;

  // Stage 1: rate and depth clamp, write qualification, range width.
  logic               s1_valid_r;
  side_t              s1_side_r;
  logic [31:0]        s1_time_r;
  logic [23:0]        s1_rate_r;
  logic [15:0]        s1_start_r;
  side_t              s1_side_nxt;
  logic [23:0]        rate_nxt;
  logic signed [16:0] depth_nxt;

  // Stage 2: phase accumulation.
  logic               s2_valid_r;
  side_t              s2_side_r;
  logic [15:0]        s2_phase_r;
  logic [55:0]        tr_prod;
  logic [15:0]        phase_nxt;

  // The whole pipeline moves together, so ready is the shared advance.
  assign in_ch.ready = adv;

  // Clamp the rate: below the minimum wins over above the maximum.
  always_comb begin
    if (in_ch.lfo_rate < cfg.min_rate) begin
      rate_nxt = cfg.min_rate;
    end else if (in_ch.lfo_rate > cfg.max_rate) begin
      rate_nxt = cfg.max_rate;
    end else begin
      rate_nxt = in_ch.lfo_rate;
    end
  end

  // Clamp the depth to plus or minus one.
  always_comb begin
    if (in_ch.route_depth > ONE_Q15) begin
      depth_nxt = ONE_Q15;
    end else if (in_ch.route_depth < NEG_ONE_Q15) begin
      depth_nxt = NEG_ONE_Q15;
    end else begin
      depth_nxt = in_ch.route_depth;
    end
  end

  // Collect the fields that travel with the route.
  always_comb begin
    s1_side_nxt.wr_en = in_ch.target_present & in_ch.source_active &
                        (in_ch.route_depth != '0);
    s1_side_nxt.last  = in_ch.last_entry;
    s1_side_nxt.uni   = in_ch.unipolar;
    s1_side_nxt.shape = in_ch.lfo_shape;
    s1_side_nxt.depth = depth_nxt;
    s1_side_nxt.base  = in_ch.base_value;
    s1_side_nxt.lo    = in_ch.range_minimum;
    s1_side_nxt.hi    = in_ch.range_maximum;
    s1_side_nxt.diff  = 33'(in_ch.range_maximum) - 33'(in_ch.range_minimum);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_side_r  <= s1_side_nxt;
      s1_time_r  <= in_ch.time_seconds;
      s1_rate_r  <= rate_nxt;
      s1_start_r <= in_ch.start_phase;
    end
  end

  // Phase is the fraction of time times rate plus the start phase.
  assign tr_prod   = 56'(s1_time_r) * 56'(s1_rate_r);
  assign phase_nxt = tr_prod[31:16] + s1_start_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_side_r  <= s1_side_r;
      s2_phase_r <= phase_nxt;
    end
  end

  assign ph_beat.valid = s2_valid_r;
  assign ph_beat.side  = s2_side_r;
  assign ph_beat.phase = s2_phase_r;

endmodule

// ----- design/lrm_wave.sv -----
`timescale 1ns / 1ps

module lrm_wave #(
  parameter int SINE_TABLE_DEPTH = lrm_pkg::SINE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  lrm_pkg::phs_beat_t ph_beat,
  output lrm_pkg::wav_beat_t w_beat
);
  import lrm_pkg::*;

  localparam int IDX_W = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int SCL_W = 14 + IDX_W;
  localparam longint unsigned TWO_D = 64'(2 * SINE_TABLE_DEPTH);
  localparam logic [IDX_W-1:0] D_IDX = IDX_W'(SINE_TABLE_DEPTH);

  typedef logic [15:0] rom_t [SINE_TABLE_DEPTH + 1];

  // One quarter-wave entry: Taylor series of sin in Q30, rounded to Q15.
  function automatic logic [15:0] sine_entry(input int k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    longint          v;
    x    = (PI_Q30 * 64'(k)) / TWO_D;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (int n = 1; n <= 8; n++) begin
      term = ((term * x2) >> 30) / SERIES_DIV[n - 1];
      if (n % 2 == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    v = (sum * 64'sd32768 + 64'sd536870912) >>> 30;
    if (v > 64'sd32768) begin
      v = 64'sd32768;
    end
    return 16'(v);
  endfunction

  function automatic rom_t build_rom();
    rom_t rom;
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      rom[k] = sine_entry(k);
    end
    return rom;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  // Stage 3: table index for sine, direct value for the other shapes.
  logic               s3_valid_r;
  side_t              s3_side_r;
  logic [IDX_W-1:0]   s3_idx_r;
  logic               s3_neg_r;
  logic               s3_sine_r;
  logic signed [16:0] s3_wave_r;
  logic [1:0]         quad;
  logic [SCL_W-1:0]   idx_scaled;
  logic [IDX_W-1:0]   idx_lim;
  logic [IDX_W-1:0]   idx_nxt;
  logic [15:0]        tri_s;
  logic [16:0]        tri_mag;
  logic signed [17:0] tri_w;
  logic signed [16:0] wave_nxt;

  // Stage 4: table read, sign and unipolar mapping.
  logic               s4_valid_r;
  side_t              s4_side_r;
  logic signed [16:0] s4_wave_r;
  logic signed [16:0] sine_w;
  logic signed [16:0] sel_w;
  logic signed [17:0] uni_sum;
  logic signed [16:0] wave4_nxt;

  // Scale the low phase bits to the table depth, rounding to nearest.
  assign quad       = ph_beat.phase[15:14];
  assign idx_scaled = SCL_W'(ph_beat.phase[13:0]) * SCL_W'(SINE_TABLE_DEPTH) +
                      SCL_W'(8192);
  assign idx_lim    = (idx_scaled[SCL_W-1:14] > D_IDX) ? D_IDX : idx_scaled[SCL_W-1:14];
  assign idx_nxt    = quad[0] ? (D_IDX - idx_lim) : idx_lim;

  // Triangle is shifted a quarter cycle so that it starts at zero and rises.
  assign tri_s   = ph_beat.phase + 16'hC000;
  assign tri_mag = tri_s[15] ? 17'({1'b0, tri_s} - 17'd32768) :
                               (17'd32768 - 17'({1'b0, tri_s}));
  assign tri_w   = $signed({tri_mag, 1'b0}) - 18'sd32768;

  always_comb begin
    case (ph_beat.side.shape)
      SHAPE_TRIANGLE: wave_nxt = tri_w[16:0];
      SHAPE_SQUARE:   wave_nxt = ph_beat.phase[15] ? NEG_ONE_Q15 : ONE_Q15;
      SHAPE_SAW:      wave_nxt = $signed({1'b0, ph_beat.phase}) - ONE_Q15;
      default:        wave_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (adv) begin
      s3_valid_r <= ph_beat.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_side_r <= ph_beat.side;
      s3_idx_r  <= idx_nxt;
      s3_neg_r  <= quad[1];
      s3_sine_r <= (ph_beat.side.shape == SHAPE_SINE);
      s3_wave_r <= wave_nxt;
    end
  end

  // Look up the quarter wave and apply the half-cycle sign.
  assign sine_w = s3_neg_r ? -$signed({1'b0, SINE_ROM[s3_idx_r]}) :
                              $signed({1'b0, SINE_ROM[s3_idx_r]});
  assign sel_w  = s3_sine_r ? sine_w : s3_wave_r;

  // Unipolar maps -1..1 onto 0..1; the sum is never negative here.
  assign uni_sum   = 18'(sel_w) + 18'sd32768;
  assign wave4_nxt = s3_side_r.uni ? $signed(uni_sum[17:1]) : sel_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else if (adv) begin
      s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_side_r <= s3_side_r;
      s4_wave_r <= wave4_nxt;
    end
  end

  assign w_beat.valid = s4_valid_r;
  assign w_beat.side  = s4_side_r;
  assign w_beat.wave  = s4_wave_r;

endmodule

// ----- design/lrm_scale.sv -----
`timescale 1ns / 1ps

module lrm_scale (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  lrm_pkg::wav_beat_t w_beat,
  lrm_out_if.source          out_ch
);
  import lrm_pkg::*;

  // Stage 5: depth times wave, at most 2^30 in magnitude.
  logic               s5_valid_r;
  side_t              s5_side_r;
  logic signed [31:0] s5_dw_r;
  logic signed [33:0] dw_full;

  // Stage 6: times the range width, below 2^62 in magnitude.
  logic               s6_valid_r;
  side_t              s6_side_r;
  logic signed [63:0] s6_prod_r;
  logic signed [64:0] prod_full;

  // Stage 7: scaled by 2^-30, rounded half away from zero.
  logic               s7_valid_r;
  side_t              s7_side_r;
  logic signed [33:0] s7_delta_r;
  logic signed [63:0] rnd;

  // Output register.
  logic               out_valid_r;
  logic signed [31:0] out_value_r;
  logic               out_wr_en_r;
  logic               out_last_r;
  logic signed [34:0] sum_w;
  logic signed [34:0] lo_w;
  logic signed [34:0] hi_w;
  logic signed [34:0] clip_w;

  assign dw_full = 34'(w_beat.side.depth) * 34'(w_beat.wave);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_valid_r <= 1'b0;
    end else if (adv) begin
      s5_valid_r <= w_beat.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_side_r <= w_beat.side;
      s5_dw_r   <= dw_full[31:0];
    end
  end

  assign prod_full = 65'(s5_dw_r) * 65'(s5_side_r.diff);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_valid_r <= 1'b0;
    end else if (adv) begin
      s6_valid_r <= s5_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_side_r <= s5_side_r;
      s6_prod_r <= prod_full[63:0];
    end
  end

  // A negative product rounds with one less so that ties move away from zero.
  assign rnd = s6_prod_r + (s6_prod_r[63] ? 64'sd536870911 : 64'sd536870912);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_valid_r <= 1'b0;
    end else if (adv) begin
      s7_valid_r <= s6_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s7_side_r  <= s6_side_r;
      s7_delta_r <= rnd[63:30];
    end
  end

  // Add the base, raise to the minimum, then lower to the maximum.
  assign sum_w = 35'(s7_side_r.base) + 35'(s7_delta_r);
  assign lo_w  = 35'(s7_side_r.lo);
  assign hi_w  = 35'(s7_side_r.hi);

  always_comb begin
    clip_w = sum_w;
    if (clip_w < lo_w) begin
      clip_w = lo_w;
    end
    if (clip_w > hi_w) begin
      clip_w = hi_w;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s7_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_value_r <= s7_side_r.wr_en ? clip_w[31:0] : '0;
      out_wr_en_r <= s7_side_r.wr_en;
      out_last_r  <= s7_side_r.last;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.written_value = out_value_r;
  assign out_ch.write_enable  = out_wr_en_r;
  assign out_ch.last_result   = out_last_r;

endmodule

// ----- design/lfo_route_modulator.sv -----
// A route accepted on the input channel passes the eight register stages, the
// output register included, before it appears on the result channel.
// Throughput: one route per cycle; the eight-stage pipeline advances whenever
// the output register is empty or its beat is taken, else every stage holds.
// Reset (synchronous, active low) empties the pipeline and restores the rate
// limits to their defaults; the sine table is constant and needs no fill.
`timescale 1ns / 1ps

module lfo_route_modulator #(
  parameter int SINE_TABLE_DEPTH = lrm_pkg::SINE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  lrm_in_if.sink                         in_ch,
  lrm_out_if.source                      out_ch,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [lrm_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [lrm_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [lrm_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);
  import lrm_pkg::*;

  cfg_t      cfg;
  phs_beat_t ph_beat;
  wav_beat_t w_beat;
  logic      adv;

  // The pipeline moves when the output register can take a new beat.
  assign adv = !out_ch.valid || out_ch.ready;

  lrm_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  lrm_phase u_phase (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .cfg     (cfg),
    .in_ch   (in_ch),
    .ph_beat (ph_beat)
  );

  lrm_wave #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_wave (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .ph_beat (ph_beat),
    .w_beat  (w_beat)
  );

  lrm_scale u_scale (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .w_beat (w_beat),
    .out_ch (out_ch)
  );

  // The waveform never leaves plus or minus one.
  a_wave_range: assert property (@(posedge clk) disable iff (!rst_n)
    w_beat.valid |-> (w_beat.wave <= ONE_Q15) && (w_beat.wave >= NEG_ONE_Q15))
    else $error("waveform out of range");

  // A unipolar waveform is never negative.
  a_uni_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    w_beat.valid && w_beat.side.uni |-> w_beat.wave >= 17'sd0)
    else $error("unipolar waveform negative");

  // A suppressed write carries a zero value.
  a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.write_enable |-> out_ch.written_value == 32'sd0)
    else $error("value present without write enable");

  // While the result beat waits, the inner stages hold their beats.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> $stable(ph_beat) && $stable(w_beat))
    else $error("pipeline moved during stall");

endmodule
